/* sv/jtt_pkg.sv */
// shared types, TAP state codes and the TAP transition function for the tracker
package jtt_pkg;

  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 6;
  localparam int unsigned PatternW = 6;
  localparam int unsigned TapStateW = 4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgFixupEnable = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgCapturePattern = 1'd1;

  localparam logic FixupEnableReset = 1'b1;
  localparam logic [PatternW-1:0] CapturePatternReset = 6'h09;

  // TAP controller states
  localparam logic [TapStateW-1:0] StTlr = 4'd0;
  localparam logic [TapStateW-1:0] StRti = 4'd1;
  localparam logic [TapStateW-1:0] StSelDr = 4'd2;
  localparam logic [TapStateW-1:0] StCapDr = 4'd3;
  localparam logic [TapStateW-1:0] StShiftDr = 4'd4;
  localparam logic [TapStateW-1:0] StExit1Dr = 4'd5;
  localparam logic [TapStateW-1:0] StPauseDr = 4'd6;
  localparam logic [TapStateW-1:0] StExit2Dr = 4'd7;
  localparam logic [TapStateW-1:0] StUpdDr = 4'd8;
  localparam logic [TapStateW-1:0] StSelIr = 4'd9;
  localparam logic [TapStateW-1:0] StCapIr = 4'd10;
  localparam logic [TapStateW-1:0] StShiftIr = 4'd11;
  localparam logic [TapStateW-1:0] StExit1Ir = 4'd12;
  localparam logic [TapStateW-1:0] StPauseIr = 4'd13;
  localparam logic [TapStateW-1:0] StExit2Ir = 4'd14;
  localparam logic [TapStateW-1:0] StUpdIr = 4'd15;

  typedef struct packed {
    logic tms_bit;
    logic raw_tdo_bit;
    logic restart;
  } in_req_t;

  typedef struct packed {
    logic tdo_bit;
    logic [TapStateW-1:0] tap_state_out;
    logic replaced;
  } out_req_t;

  typedef struct packed {
    logic fixup_enable;
    logic [PatternW-1:0] capture_pattern;
  } cfg_t;

  function automatic logic [TapStateW-1:0] tap_next(input logic [TapStateW-1:0] cur,
                                                    input logic tms);
    logic [TapStateW-1:0] nxt;
    unique case (cur)
      StTlr:     nxt = tms ? StTlr : StRti;
      StRti:     nxt = tms ? StSelDr : StRti;
      StSelDr:   nxt = tms ? StSelIr : StCapDr;
      StCapDr:   nxt = tms ? StExit1Dr : StShiftDr;
      StShiftDr: nxt = tms ? StExit1Dr : StShiftDr;
      StExit1Dr: nxt = tms ? StUpdDr : StPauseDr;
      StPauseDr: nxt = tms ? StExit2Dr : StPauseDr;
      StExit2Dr: nxt = tms ? StUpdDr : StShiftDr;
      StUpdDr:   nxt = tms ? StSelDr : StRti;
      StSelIr:   nxt = tms ? StTlr : StCapIr;
      StCapIr:   nxt = tms ? StExit1Ir : StShiftIr;
      StShiftIr: nxt = tms ? StExit1Ir : StShiftIr;
      StExit1Ir: nxt = tms ? StUpdIr : StPauseIr;
      StPauseIr: nxt = tms ? StExit2Ir : StPauseIr;
      StExit2Ir: nxt = tms ? StUpdIr : StShiftIr;
      StUpdIr:   nxt = tms ? StSelDr : StRti;
      default:   nxt = StTlr;
    endcase
    return nxt;
  endfunction

endpackage

/* sv/jtag_tap_tracker_ir_capture_fix.sv */
// top level of the JTAG TAP tracker with IR capture rewrite
// path: an accepted request is held in the input reg, then its result in the result reg
// throughput: one request per cycle, sustained while out_ready_i does not stall the result reg
// the combinational TAP step and capture counter update set this rate
// reset: TAP tracking goes to Test-Logic-Reset, disarmed, index 0
// reset: fixup enabled, capture pattern 0x09, both pipeline stages empty
module jtag_tap_tracker_ir_capture_fix import jtt_pkg::*; #(
  parameter int unsigned IR_CAPTURE_BITS = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // input requests
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_req_t             in_data_i,
  // result requests
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_req_t            out_data_o
);

  localparam int unsigned IdxW = $clog2(IR_CAPTURE_BITS + 1);

  // configuration registers
  cfg_t cfg_q;

  // input stage
  logic    in_valid_q;
  in_req_t in_req_q;

  // tracking state
  logic [TapStateW-1:0] state_q, state_d;
  logic                 armed_q, armed_d;
  logic [IdxW-1:0]      index_q, index_d;

  // result stage
  logic     out_valid_q;
  out_req_t out_req_q, out_req_d;

  // the input stage moves on when the result stage is empty or draining
  logic advance;
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fixup_enable    <= FixupEnableReset;
      cfg_q.capture_pattern <= CapturePatternReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgFixupEnable:    cfg_q.fixup_enable <= cfg_data_i[0];
        CfgCapturePattern: cfg_q.capture_pattern <= cfg_data_i[PatternW-1:0];
        default: ;
      endcase
    end
  end

  // input register: takes a new request whenever the stage frees up
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_req_q <= in_data_i;
    end
  end

  // one tracker step per request leaving the input stage
  jtt_step #(
    .IR_CAPTURE_BITS(IR_CAPTURE_BITS)
  ) u_step (
    .req_i   (in_req_q),
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .armed_i (armed_q),
    .index_i (index_q),
    .state_o (state_d),
    .armed_o (armed_d),
    .index_o (index_d),
    .rsp_o   (out_req_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StTlr;
      armed_q <= 1'b0;
      index_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
      armed_q <= armed_d;
      index_q <= index_d;
    end
  end

  // result register: holds until taken, refilled in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_req_q <= out_req_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_req_q;

endmodule

/* sv/jtt_step.sv */
// per-request tracker update: with fixup enabled, TAP state step, capture arming and TDO rewrite
module jtt_step import jtt_pkg::*; #(
  parameter int unsigned IR_CAPTURE_BITS = 6
) (
  input  in_req_t                                   req_i,
  input  cfg_t                                      cfg_i,
  input  logic [TapStateW-1:0]                      state_i,
  input  logic                                      armed_i,
  input  logic [$clog2(IR_CAPTURE_BITS+1)-1:0]      index_i,
  output logic [TapStateW-1:0]                      state_o,
  output logic                                      armed_o,
  output logic [$clog2(IR_CAPTURE_BITS+1)-1:0]      index_o,
  output out_req_t                                  rsp_o
);

  localparam int unsigned IdxW = $clog2(IR_CAPTURE_BITS + 1);

  logic [TapStateW-1:0] prev;
  logic                 armed;
  logic [IdxW-1:0]      index;
  logic [TapStateW-1:0] next;
  logic [31:0]          pattern_ext;
  logic                 tdo;
  logic                 repl;

  assign pattern_ext = 32'(cfg_i.capture_pattern);

  always_comb begin
    // restart clears tracking before this bit is handled
    prev  = req_i.restart ? StTlr : state_i;
    armed = req_i.restart ? 1'b0 : armed_i;
    index = req_i.restart ? '0 : index_i;
    next  = tap_next(prev, req_i.tms_bit);
    tdo   = req_i.raw_tdo_bit;
    repl  = 1'b0;

    state_o = prev;
    armed_o = armed;
    index_o = index;

    if (cfg_i.fixup_enable) begin
      state_o = next;
      priority if (prev == StCapIr && next == StShiftIr) begin
        armed_o = 1'b1;
        index_o = '0;
      end else if (prev == StShiftIr && armed && index < IdxW'(IR_CAPTURE_BITS)) begin
        tdo  = pattern_ext[5'(index)];
        repl = 1'b1;
        if (next != StShiftIr) begin
          armed_o = 1'b0;
          index_o = '0;
        end else begin
          index_o = index + IdxW'(1);
        end
      end else if (next != StShiftIr && prev != StCapIr) begin
        armed_o = 1'b0;
        index_o = '0;
      end else begin
        armed_o = armed;
        index_o = index;
      end
    end

    rsp_o.tdo_bit       = tdo;
    rsp_o.tap_state_out = state_o;
    rsp_o.replaced      = repl;
  end

endmodule
